FILE: hdl/sql_pkg.sv
// Shared types, constants and helper functions of the SARSA(lambda) value update core.
package sql_pkg;

   // Request codes carried on req_type.
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_STEP  = 2'd1;
   localparam logic [1:0] REQ_END   = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_NUM_ACTIONS   = 3'd0;
   localparam logic [2:0] CSR_LEARN_RATE    = 3'd1;
   localparam logic [2:0] CSR_DISCOUNT      = 3'd2;
   localparam logic [2:0] CSR_TRACE_DECAY   = 3'd3;
   localparam logic [2:0] CSR_EXPLORE_RATE  = 3'd4;
   localparam logic [2:0] CSR_INITIAL_VALUE = 3'd5;

   // Fixed point constants.
   localparam logic [16:0] FRAC_ONE = 17'd65536;
   localparam int FRAC_W = 17;
   localparam int VALUE_W = 32;

   // Shared remainder unit widths; the dividend is a 4-bit draw.
   localparam int DVD_W = 4;
   localparam int DIV_W = 17;

   // Request and response of the remainder unit.
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] remainder;
   } mod_rsp_type;

   // Operands that stay fixed during one sweep.
   typedef struct packed {
      logic [FRAC_W-1:0]         alpha;
      logic [FRAC_W-1:0]         lam;
      logic signed [VALUE_W-1:0] target;
      logic                      finish;
   } sweep_ctl_type;

   // Write-back of one swept entry.
   typedef struct packed {
      logic                      we;
      logic signed [VALUE_W-1:0] q;
      logic [FRAC_W-1:0]         e;
   } sweep_wr_type;

   // Clamp a wide signed sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Fractions above one act as one.
   function automatic logic [16:0] frac_clamp(input logic [16:0] v);
      return (v > FRAC_ONE) ? FRAC_ONE : v;
   endfunction

endpackage

FILE: hdl/sql_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module sql_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 14
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [(1 << ADDR_W)];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/sql_mod_unit.sv
// Restoring remainder unit, one dividend bit per cycle.
module sql_mod_unit import sql_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req,
   output mod_rsp_type rsp
);

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W:0]   rem_shift;

   // Shift in the next dividend bit and subtract the divisor when it fits.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         div_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = DIV_W'(rem_shift - {1'b0, div_ff});
         end else begin
            rem_in = DIV_W'(rem_shift);
         end
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand and remainder registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

FILE: hdl/sql_update_pipe.sv
// Pipelined value and trace update applied to each swept table entry.
module sql_update_pipe import sql_pkg::*; #(
   parameter int ADDR_W = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sweep_ctl_type             ctl,
   input  logic                      in_valid,
   input  logic                      in_use,
   input  logic [ADDR_W-1:0]         in_addr,
   input  logic signed [VALUE_W-1:0] in_q,
   input  logic [FRAC_W-1:0]         in_e,
   output sweep_wr_type              wr,
   output logic [ADDR_W-1:0]         wr_addr,
   output logic                      busy
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic act1_ff, act2_ff, act3_ff, act4_ff, act5_ff;
   logic [ADDR_W-1:0] addr1_ff, addr2_ff, addr3_ff, addr4_ff, addr5_ff;
   logic signed [VALUE_W-1:0] q1_ff, q2_ff, q3_ff, q4_ff, q5_ff;
   logic [FRAC_W-1:0] ne2_ff, ne3_ff, ne4_ff, ne5_ff;

   logic [33:0]        ae_prod1_ff, ae_prod1_in;
   logic [33:0]        el1_ff, el1_in;
   logic signed [32:0] err1_ff, err1_in, err2_ff;
   logic [33:0]        ae_sum, el_sum;
   logic [FRAC_W-1:0]  ae2_ff;
   logic [32:0]        p_lo3_ff, p_lo3_in;
   logic signed [34:0] p_hi3_ff, p_hi3_in;
   logic signed [50:0] prod4_ff, prod4_in;
   logic signed [50:0] prod_rnd;
   logic signed [34:0] delta5_ff;
   logic signed [47:0] q_sum;

   // Stage one: alpha * e, e * lambda and the error against the target.
   assign ae_prod1_in = 34'(ctl.alpha) * 34'(in_e);
   assign el1_in      = 34'(in_e) * 34'(ctl.lam);
   assign err1_in     = 33'(ctl.target) - 33'(in_q);

   // Stage two: round both products back to Q1.16.
   assign ae_sum = ae_prod1_ff + 34'd32768;
   assign el_sum = el1_ff + 34'd32768;

   // Stage three: scaled error as two partial products.
   assign p_lo3_in = 33'(ae2_ff) * 33'(err2_ff[15:0]);
   assign p_hi3_in = 35'($signed({1'b0, ae2_ff})) * 35'($signed(err2_ff[32:16]));

   // Stage four: join the partial products.
   assign prod4_in = (51'(p_hi3_ff) <<< 16) + $signed({18'd0, p_lo3_ff});

   // Stage five: round the product.
   assign prod_rnd = prod4_ff + 51'sd32768;

   // Saturating add feeds the write port.
   assign q_sum    = 48'(q5_ff) + 48'(delta5_ff);
   assign wr.we    = v5_ff & act5_ff;
   assign wr.q     = sat32(q_sum);
   assign wr.e     = ne5_ff;
   assign wr_addr  = addr5_ff;
   assign busy     = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;

   // Valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      act1_ff     <= in_use & (in_e != '0);
      addr1_ff    <= in_addr;
      q1_ff       <= in_q;
      ae_prod1_ff <= ae_prod1_in;
      el1_ff      <= el1_in;
      err1_ff     <= err1_in;

      act2_ff  <= act1_ff;
      addr2_ff <= addr1_ff;
      q2_ff    <= q1_ff;
      err2_ff  <= err1_ff;
      ae2_ff   <= ae_sum[32:16];
      ne2_ff   <= ctl.finish ? '0 : el_sum[32:16];

      act3_ff  <= act2_ff;
      addr3_ff <= addr2_ff;
      q3_ff    <= q2_ff;
      ne3_ff   <= ne2_ff;
      p_lo3_ff <= p_lo3_in;
      p_hi3_ff <= p_hi3_in;

      act4_ff  <= act3_ff;
      addr4_ff <= addr3_ff;
      q4_ff    <= q3_ff;
      ne4_ff   <= ne3_ff;
      prod4_ff <= prod4_in;

      act5_ff   <= act4_ff;
      addr5_ff  <= addr4_ff;
      q5_ff     <= q4_ff;
      ne5_ff    <= ne4_ff;
      delta5_ff <= prod_rnd[50:16];
   end

endmodule

FILE: hdl/sarsa_lambda_q_update_core.sv
// Top level of the tabular SARSA(lambda) learner with replacing traces.
// A transaction is accepted when start is high while busy is low, and exactly one result
// follows: rsp_strobe is high for one cycle with the chosen action, and the receiver cannot
// stall it. Work is one transaction at a time. After reset the visited map is cleared, one
// state per cycle, over all 2**clog2(NUM_STATES) states (1024 by default) with busy high.
// Episode start, step and episode end each pass once over every entry of the trace memory,
// one entry per cycle, over all 2**(clog2(NUM_STATES)+clog2(MAX_ACTIONS)) entries (16384 by default);
// start uses it to zero all traces, step and episode end to update values and traces.
// Besides that pass, a step also forms the target and drains the update pipeline; a greedy
// choice reads each action in use twice, and a state's first visit writes the initial value
// to all 2**clog2(MAX_ACTIONS) entries of its row. An unknown request is answered in the
// cycle after it is accepted.
module sarsa_lambda_q_update_core import sql_pkg::*; #(
   parameter int NUM_STATES  = 1024,
   parameter int MAX_ACTIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [9:0]  req_state_index,
   input  logic [31:0] req_reward,
   input  logic [15:0] req_explore_draw,
   input  logic [3:0]  req_random_action,
   input  logic [3:0]  req_tie_draw,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_chosen_action,
   output logic        rsp_action_valid,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int SW     = $clog2(NUM_STATES);
   localparam int AW     = $clog2(MAX_ACTIONS);
   localparam int NW     = $clog2(MAX_ACTIONS + 1);
   localparam int ADDR_W = SW + AW;

   // Reciprocal that gives the exact quotient of a 10-bit index by NUM_STATES.
   localparam int     RCP_K = 10 + $clog2(NUM_STATES);
   localparam longint RCP_M = ((longint'(1) << RCP_K) + longint'(NUM_STATES) - 1)
                              / longint'(NUM_STATES);

   typedef enum logic [17:0] {
      ST_CLEAR = 18'b1 << 0,
      ST_IDLE  = 18'b1 << 1,
      ST_TCLR  = 18'b1 << 2,
      ST_VRD   = 18'b1 << 3,
      ST_VCHK  = 18'b1 << 4,
      ST_INIT  = 18'b1 << 5,
      ST_PICK  = 18'b1 << 6,
      ST_AMOD  = 18'b1 << 7,
      ST_SCAN1 = 18'b1 << 8,
      ST_TMOD  = 18'b1 << 9,
      ST_SCAN2 = 18'b1 << 10,
      ST_ACT   = 18'b1 << 11,
      ST_QWAIT = 18'b1 << 12,
      ST_TGT1  = 18'b1 << 13,
      ST_TGT2  = 18'b1 << 14,
      ST_SWEEP = 18'b1 << 15,
      ST_DRAIN = 18'b1 << 16,
      ST_TSET  = 18'b1 << 17
   } state_type;

   // Configuration registers.
   logic [4:0]         num_actions_ff;
   logic [16:0]        learn_rate_ff, discount_ff, trace_decay_ff, explore_rate_ff;
   logic signed [31:0] initial_value_ff;

   // Control state.
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              scan_rd_ff, scan_rd_in;
   logic              sweep_rd_ff, sweep_rd_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   mod_req_type       mod_req_ff, mod_req_in;

   // Transaction payload.
   logic [1:0]         type_ff, type_in;
   logic signed [31:0] reward_ff, reward_in;
   logic [15:0]        draw_ff, draw_in;
   logic [3:0]         ra_ff, ra_in;
   logic [3:0]         td_ff, td_in;
   logic [SW-1:0]      s_ff, s_in;
   logic [AW-1:0]      act_ff, act_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic [NW-1:0]      ties_ff, ties_in;
   logic [NW-1:0]      k_ff, k_in;
   logic               found_ff, found_in;
   logic signed [31:0] best_ff, best_in;
   logic signed [31:0] target_ff, target_in;
   logic               finish_ff, finish_in;
   logic signed [49:0] gmul_ff, gmul_in;
   logic signed [33:0] tr_ff, tr_in;
   logic signed [49:0] gmul_rnd;
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [3:0]         rsp_action_ff, rsp_action_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // State index reduced modulo NUM_STATES.
   logic [21:0] sidx_prod;
   logic [9:0]  sidx_quot;
   logic [31:0] sidx_rem;

   // Derived configuration.
   logic [NW-1:0] n_act;
   logic [16:0]   alpha_c, gamma_c, lam_c, eps_c;

   // Memory ports.
   logic              val_we, tr_we, vis_we;
   logic [ADDR_W-1:0] val_wa, val_ra, tr_wa, tr_ra;
   logic [31:0]       val_wd, val_rd;
   logic [16:0]       tr_wd, tr_rd;
   logic [SW-1:0]     vis_wa, vis_ra;
   logic              vis_wd, vis_rd;
   logic signed [31:0] q_rd;
   logic [AW-1:0]     rd_j;

   // Unit connections.
   mod_rsp_type       mod_rsp;
   sweep_ctl_type     sweep_ctl;
   sweep_wr_type      pipe_wr;
   logic [ADDR_W-1:0] pipe_addr;
   logic              pipe_busy;
   logic              pipe_use;

   // Active action count and clamped fractions.
   always_comb begin
      if (num_actions_ff == '0) begin
         n_act = NW'(1);
      end else if (7'(num_actions_ff) > 7'(MAX_ACTIONS)) begin
         n_act = NW'(MAX_ACTIONS);
      end else begin
         n_act = NW'(num_actions_ff);
      end
   end

   assign alpha_c = frac_clamp(learn_rate_ff);
   assign gamma_c = frac_clamp(discount_ff);
   assign lam_c   = frac_clamp(trace_decay_ff);
   assign eps_c   = frac_clamp(explore_rate_ff);

   // Quotient by reciprocal multiplication, then the remainder by one subtraction.
   assign sidx_prod = 22'(req_state_index) * 22'(RCP_M);
   assign sidx_quot = 10'(sidx_prod >> RCP_K);
   assign sidx_rem  = 32'(req_state_index) - 32'(sidx_quot) * 32'(NUM_STATES);

   assign q_rd     = $signed(val_rd);
   assign rd_j     = rd_addr_ff[AW-1:0];
   assign gmul_in  = 50'($signed({1'b0, gamma_c})) * 50'(q_rd);
   assign gmul_rnd = gmul_ff + 50'sd32768;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      scan_rd_in    = 1'b0;
      sweep_rd_in   = 1'b0;
      rsp_strobe_in = 1'b0;
      mod_req_in    = mod_req_ff;
      mod_req_in.start = 1'b0;
      type_in       = type_ff;
      reward_in     = reward_ff;
      draw_in       = draw_ff;
      ra_in         = ra_ff;
      td_in         = td_ff;
      s_in          = s_ff;
      act_in        = act_ff;
      cnt_in        = cnt_ff;
      ties_in       = ties_ff;
      k_in          = k_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      target_in     = target_ff;
      finish_in     = finish_ff;
      tr_in         = tr_ff;
      rd_addr_in    = rd_addr_ff;
      rsp_action_in = rsp_action_ff;
      rsp_valid_in  = rsp_valid_ff;

      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff[SW-1:0] == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               type_in   = req_type;
               reward_in = $signed(req_reward);
               draw_in   = req_explore_draw;
               ra_in     = req_random_action;
               td_in     = req_tie_draw;
               case (req_type)
                  REQ_START, REQ_STEP: begin
                     s_in     = SW'(sidx_rem);
                     addr_in  = '0;
                     state_in = (req_type == REQ_START) ? ST_TCLR : ST_VRD;
                  end
                  REQ_END: begin
                     target_in = $signed(req_reward);
                     finish_in = 1'b1;
                     addr_in   = '0;
                     state_in  = ST_SWEEP;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_action_in = '0;
                     rsp_valid_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_TCLR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == '1) begin
               state_in = ST_VRD;
            end
         end
         ST_VRD: begin
            state_in = ST_VCHK;
         end
         ST_VCHK: begin
            cnt_in = '0;
            state_in = vis_rd ? ST_PICK : ST_INIT;
         end
         ST_INIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[AW-1:0] == '1) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cnt_in = '0;
            if ({1'b0, draw_ff} < eps_c) begin
               mod_req_in = '{start: 1'b1, dividend: DVD_W'(ra_ff),
                              divisor: DIV_W'(n_act)};
               state_in = ST_AMOD;
            end else begin
               state_in = ST_SCAN1;
            end
         end
         ST_AMOD: begin
            if (mod_rsp.done) begin
               act_in   = mod_rsp.remainder[AW-1:0];
               state_in = ST_ACT;
            end
         end
         ST_SCAN1: begin
            // Running maximum and the number of entries equal to it.
            if (cnt_ff < n_act) begin
               scan_rd_in = 1'b1;
               rd_addr_in = {s_ff, cnt_ff[AW-1:0]};
               cnt_in     = cnt_ff + 1'b1;
            end
            if (scan_rd_ff) begin
               if ((rd_j == '0) || (q_rd > best_ff)) begin
                  best_in = q_rd;
                  ties_in = NW'(1);
               end else if (q_rd == best_ff) begin
                  ties_in = ties_ff + 1'b1;
               end
            end
            if ((cnt_ff == n_act) && !scan_rd_ff) begin
               mod_req_in = '{start: 1'b1, dividend: DVD_W'(td_ff),
                              divisor: DIV_W'(ties_ff)};
               state_in = ST_TMOD;
            end
         end
         ST_TMOD: begin
            if (mod_rsp.done) begin
               k_in     = mod_rsp.remainder[NW-1:0];
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = ST_SCAN2;
            end
         end
         ST_SCAN2: begin
            // Pick the k-th maximum in ascending action order.
            if (cnt_ff < n_act) begin
               scan_rd_in = 1'b1;
               rd_addr_in = {s_ff, cnt_ff[AW-1:0]};
               cnt_in     = cnt_ff + 1'b1;
            end
            if (scan_rd_ff && (q_rd == best_ff) && !found_ff) begin
               if (k_ff == '0) begin
                  act_in   = rd_j;
                  found_in = 1'b1;
               end else begin
                  k_in = k_ff - 1'b1;
               end
            end
            if ((cnt_ff == n_act) && !scan_rd_ff) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            state_in = (type_ff == REQ_START) ? ST_TSET : ST_QWAIT;
         end
         ST_QWAIT: begin
            state_in = ST_TGT1;
         end
         ST_TGT1: begin
            tr_in    = $signed(gmul_rnd[49:16]);
            state_in = ST_TGT2;
         end
         ST_TGT2: begin
            target_in = sat32(48'(reward_ff) + 48'(tr_ff));
            finish_in = 1'b0;
            addr_in   = '0;
            state_in  = ST_SWEEP;
         end
         ST_SWEEP: begin
            sweep_rd_in = 1'b1;
            rd_addr_in  = addr_ff;
            addr_in     = addr_ff + 1'b1;
            if (addr_ff == '1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sweep_rd_ff && !pipe_busy) begin
               if (type_ff == REQ_END) begin
                  rsp_strobe_in = 1'b1;
                  rsp_action_in = '0;
                  rsp_valid_in  = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_TSET;
               end
            end
         end
         ST_TSET: begin
            rsp_strobe_in = 1'b1;
            rsp_action_in = 4'(act_ff);
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port selection.
   always_comb begin
      val_we = pipe_wr.we;
      val_wa = pipe_addr;
      val_wd = pipe_wr.q;
      tr_we  = pipe_wr.we;
      tr_wa  = pipe_addr;
      tr_wd  = pipe_wr.e;
      vis_we = 1'b0;
      vis_wa = s_ff;
      vis_wd = 1'b1;
      val_ra = addr_ff;
      tr_ra  = addr_ff;
      vis_ra = addr_ff[ADDR_W-1:AW];
      case (state_ff)
         ST_CLEAR: begin
            vis_we = 1'b1;
            vis_wa = addr_ff[SW-1:0];
            vis_wd = 1'b0;
         end
         ST_TCLR: begin
            tr_we = 1'b1;
            tr_wa = addr_ff;
            tr_wd = '0;
         end
         ST_VRD: begin
            vis_ra = s_ff;
         end
         ST_INIT: begin
            val_we = 1'b1;
            val_wa = {s_ff, cnt_ff[AW-1:0]};
            val_wd = initial_value_ff;
            tr_we  = 1'b1;
            tr_wa  = {s_ff, cnt_ff[AW-1:0]};
            tr_wd  = '0;
            vis_we = (cnt_ff[AW-1:0] == '1);
         end
         ST_SCAN1, ST_SCAN2: begin
            val_ra = {s_ff, cnt_ff[AW-1:0]};
         end
         ST_ACT: begin
            val_ra = {s_ff, act_ff};
         end
         ST_TSET: begin
            tr_we = 1'b1;
            tr_wa = {s_ff, act_ff};
            tr_wd = FRAC_ONE;
         end
         default: begin
            val_ra = addr_ff;
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         addr_ff          <= '0;
         scan_rd_ff       <= 1'b0;
         sweep_rd_ff      <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
         mod_req_ff       <= '0;
         num_actions_ff   <= 5'd4;
         learn_rate_ff    <= 17'd6554;
         discount_ff      <= 17'd62259;
         trace_decay_ff   <= 17'd58982;
         explore_rate_ff  <= 17'd6554;
         initial_value_ff <= '0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         scan_rd_ff    <= scan_rd_in;
         sweep_rd_ff   <= sweep_rd_in;
         rsp_strobe_ff <= rsp_strobe_in;
         mod_req_ff    <= mod_req_in;
         if (csr_write) begin
            case (csr_index)
               CSR_NUM_ACTIONS:   num_actions_ff   <= csr_wdata[4:0];
               CSR_LEARN_RATE:    learn_rate_ff    <= csr_wdata[16:0];
               CSR_DISCOUNT:      discount_ff      <= csr_wdata[16:0];
               CSR_TRACE_DECAY:   trace_decay_ff   <= csr_wdata[16:0];
               CSR_EXPLORE_RATE:  explore_rate_ff  <= csr_wdata[16:0];
               CSR_INITIAL_VALUE: initial_value_ff <= $signed(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      reward_ff     <= reward_in;
      draw_ff       <= draw_in;
      ra_ff         <= ra_in;
      td_ff         <= td_in;
      s_ff          <= s_in;
      act_ff        <= act_in;
      cnt_ff        <= cnt_in;
      ties_ff       <= ties_in;
      k_ff          <= k_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      target_ff     <= target_in;
      finish_ff     <= finish_in;
      gmul_ff       <= gmul_in;
      tr_ff         <= tr_in;
      rd_addr_ff    <= rd_addr_in;
      rsp_action_ff <= rsp_action_in;
      rsp_valid_ff  <= rsp_valid_in;
   end

   // Value, trace and visited memories.
   sql_ram #(.WIDTH(32), .ADDR_W(ADDR_W)) u_value_mem (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (val_ra),
      .rd_data (val_rd)
   );

   sql_ram #(.WIDTH(17), .ADDR_W(ADDR_W)) u_trace_mem (
      .clock   (clock),
      .wr_en   (tr_we),
      .wr_addr (tr_wa),
      .wr_data (tr_wd),
      .rd_addr (tr_ra),
      .rd_data (tr_rd)
   );

   sql_ram #(.WIDTH(1), .ADDR_W(SW)) u_visited_mem (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_wa),
      .wr_data (vis_wd),
      .rd_addr (vis_ra),
      .rd_data (vis_rd)
   );

   // Shared remainder unit for the random action and the tie pick.
   sql_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req_ff),
      .rsp   (mod_rsp)
   );

   // Sweep update pipeline; only visited states and actions in use are touched.
   assign sweep_ctl = '{alpha: alpha_c, lam: lam_c, target: target_ff, finish: finish_ff};
   assign pipe_use  = vis_rd & (NW'(rd_j) < n_act);

   sql_update_pipe #(.ADDR_W(ADDR_W)) u_pipe (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sweep_ctl),
      .in_valid (sweep_rd_ff),
      .in_use   (pipe_use),
      .in_addr  (rd_addr_ff),
      .in_q     (q_rd),
      .in_e     (tr_rd),
      .wr       (pipe_wr),
      .wr_addr  (pipe_addr),
      .busy     (pipe_busy)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_chosen_action = rsp_action_ff;
   assign rsp_action_valid  = rsp_valid_ff;

endmodule

FILE: test/sarsa_lambda_q_update_core_tb.sv
// Self-checking testbench for the SARSA(lambda) value update core.
`timescale 1ns / 100ps

module sarsa_lambda_q_update_core_tb;
   import sql_pkg::*;

   // Unknown request code, answered with no valid action.
   localparam logic [1:0] REQ_NONE = 2'd3;
   localparam int STATES = 1024;
   localparam int ACTS = 16;
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      bit          is_csr;
      logic [2:0]  csr_idx;
      logic [31:0] csr_val;
      logic [1:0]  kind;
      logic [9:0]  state;
      logic [31:0] reward;
      logic [15:0] draw;
      logic [3:0]  rand_act;
      logic [3:0]  tie;
      int          gap_pct;
   } job_type;

   typedef struct {
      logic [3:0] action;
      logic       valid;
   } choice_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [9:0]  req_state_index = '0;
   logic [31:0] req_reward = '0;
   logic [15:0] req_explore_draw = '0;
   logic [3:0]  req_random_action = '0;
   logic [3:0]  req_tie_draw = '0;
   logic        rsp_strobe;
   logic [3:0]  rsp_chosen_action;
   logic        rsp_action_valid;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   job_type    job_q[$];
   choice_type choice_q[$];
   int         errors = 0;
   int         quiet_cycles = 0;
   int         cur_gap = 0;

   // Mirror of the learner state and registers.
   logic signed [31:0] q_tab[STATES*ACTS];
   logic [16:0]        e_tab[STATES*ACTS];
   bit                 seen[STATES];
   logic [4:0]         m_nact;
   logic [16:0]        m_alpha, m_gamma, m_lambda, m_eps;
   logic signed [31:0] m_init;

   sarsa_lambda_q_update_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_state_index(req_state_index), .req_reward(req_reward),
      .req_explore_draw(req_explore_draw), .req_random_action(req_random_action),
      .req_tie_draw(req_tie_draw), .rsp_strobe(rsp_strobe),
      .rsp_chosen_action(rsp_chosen_action), .rsp_action_valid(rsp_action_valid),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rounded divide by 65536, ties toward plus infinity.
   function automatic longint round_q16(longint v);
      longint t;
      t = v + 32768;
      if (t >= 0) begin
         return t >>> 16;
      end
      return -((-t + 65535) >>> 16);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic longint unit_frac(logic [16:0] v);
      return (v > 17'd65536) ? 65536 : longint'(v);
   endfunction

   function automatic int live_actions();
      if (m_nact == 0) begin
         return 1;
      end else if (m_nact > ACTS) begin
         return ACTS;
      end
      return int'(m_nact);
   endfunction

   function automatic void learner_reset();
      foreach (seen[i]) seen[i] = 0;
      foreach (q_tab[i]) q_tab[i] = '0;
      foreach (e_tab[i]) e_tab[i] = '0;
      m_nact = 5'd4;
      m_alpha = 17'd6554;
      m_gamma = 17'd62259;
      m_lambda = 17'd58982;
      m_eps = 17'd6554;
      m_init = '0;
   endfunction

   function automatic void learner_write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         CSR_NUM_ACTIONS: m_nact = val[4:0];
         CSR_LEARN_RATE: m_alpha = val[16:0];
         CSR_DISCOUNT: m_gamma = val[16:0];
         CSR_TRACE_DECAY: m_lambda = val[16:0];
         CSR_EXPLORE_RATE: m_eps = val[16:0];
         CSR_INITIAL_VALUE: m_init = val;
         default: ;
      endcase
   endfunction

   // First visit fills a state's row with the initial value.
   function automatic void mark_visited(int s);
      if (!seen[s]) begin
         for (int j = 0; j < ACTS; j++) begin
            q_tab[s*ACTS+j] = m_init;
            e_tab[s*ACTS+j] = '0;
         end
         seen[s] = 1;
      end
   endfunction

   // Epsilon-greedy choice with ties split by the tie draw.
   function automatic int choose_action(int s, logic [15:0] draw, logic [3:0] ra,
                                        logic [3:0] td);
      int n;
      int ties;
      int k;
      logic signed [31:0] best;
      n = live_actions();
      ties = 0;
      if (longint'(draw) < unit_frac(m_eps)) begin
         return int'(ra) % n;
      end
      best = q_tab[s*ACTS];
      for (int j = 1; j < n; j++) begin
         if (q_tab[s*ACTS+j] > best) best = q_tab[s*ACTS+j];
      end
      for (int j = 0; j < n; j++) begin
         if (q_tab[s*ACTS+j] == best) ties++;
      end
      k = int'(td) % ties;
      for (int j = 0; j < n; j++) begin
         if (q_tab[s*ACTS+j] == best) begin
            if (k == 0) return j;
            k--;
         end
      end
      return 0;
   endfunction

   // Move every traced value toward the target and decay or clear its trace.
   function automatic void update_traced(logic signed [31:0] target, bit finish);
      int n;
      longint ae;
      longint err;
      n = live_actions();
      for (int s = 0; s < STATES; s++) begin
         if (seen[s]) begin
            for (int j = 0; j < n; j++) begin
               if (e_tab[s*ACTS+j] != 0) begin
                  ae = round_q16(unit_frac(m_alpha) * longint'(e_tab[s*ACTS+j]));
                  err = longint'(target) - longint'(q_tab[s*ACTS+j]);
                  q_tab[s*ACTS+j] = clamp32(longint'(q_tab[s*ACTS+j])
                                            + round_q16(ae * err));
                  e_tab[s*ACTS+j] = finish ? 17'd0 :
                     17'(round_q16(longint'(e_tab[s*ACTS+j]) * unit_frac(m_lambda)));
               end
            end
         end
      end
   endfunction

   // Expected choice for one accepted transaction.
   function automatic choice_type learner_apply(logic [1:0] kind, logic [9:0] sidx,
                                                logic [31:0] rew, logic [15:0] draw,
                                                logic [3:0] ra, logic [3:0] td);
      choice_type c;
      int s;
      int a;
      logic signed [31:0] qn;
      logic signed [31:0] target;
      c.action = '0;
      c.valid = 1'b0;
      s = int'(sidx);
      if (kind == REQ_START) begin
         foreach (e_tab[i]) e_tab[i] = '0;
         mark_visited(s);
         a = choose_action(s, draw, ra, td);
         e_tab[s*ACTS+a] = FRAC_ONE;
         c.action = 4'(a);
         c.valid = 1'b1;
      end else if (kind == REQ_STEP) begin
         mark_visited(s);
         a = choose_action(s, draw, ra, td);
         qn = q_tab[s*ACTS+a];
         target = clamp32(longint'($signed(rew))
                          + round_q16(unit_frac(m_gamma) * longint'(qn)));
         update_traced(target, 1'b0);
         e_tab[s*ACTS+a] = FRAC_ONE;
         c.action = 4'(a);
         c.valid = 1'b1;
      end else if (kind == REQ_END) begin
         update_traced($signed(rew), 1'b1);
      end
      return c;
   endfunction

   task automatic add_req(logic [1:0] kind, logic [9:0] s, logic [31:0] r,
                          logic [15:0] draw, logic [3:0] ra, logic [3:0] td);
      job_type j;
      j.is_csr = 0;
      j.csr_idx = '0;
      j.csr_val = '0;
      j.kind = kind;
      j.state = s;
      j.reward = r;
      j.draw = draw;
      j.rand_act = ra;
      j.tie = td;
      j.gap_pct = cur_gap;
      job_q.push_back(j);
   endtask

   task automatic add_csr(logic [2:0] idx, logic [31:0] val);
      job_type j;
      j = '{default: '0};
      j.is_csr = 1;
      j.csr_idx = idx;
      j.csr_val = val;
      job_q.push_back(j);
   endtask

   // Mostly small rewards so values stay readable, sometimes the full range.
   function automatic logic [31:0] pick_reward();
      if ($urandom_range(9) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
   endfunction

   function automatic logic [9:0] pick_state();
      if ($urandom_range(7) == 0) return 10'($urandom_range(0, STATES - 1));
      return 10'($urandom_range(0, 7));
   endfunction

   // Random episodes with a share of stray steps, ends and unknown codes.
   task automatic add_random(int count);
      int made;
      int steps;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) == 0) begin
            add_req($urandom_range(9) < 5 ? REQ_NONE : ($urandom_range(1) ? REQ_STEP : REQ_END),
                    10'($urandom), $urandom, 16'($urandom), 4'($urandom), 4'($urandom));
            made++;
         end else begin
            steps = $urandom_range(1, 5);
            add_req(REQ_START, pick_state(), $urandom, 16'($urandom), 4'($urandom),
                    4'($urandom));
            for (int i = 0; i < steps; i++) begin
               add_req(REQ_STEP, pick_state(), pick_reward(), 16'($urandom), 4'($urandom),
                       4'($urandom));
            end
            add_req(REQ_END, 10'($urandom), pick_reward(), 16'($urandom), 4'($urandom),
                    4'($urandom));
            made += steps + 2;
         end
      end
   endtask

   // Stimulus plan: directed cases, then three random phases with new settings.
   initial begin
      learner_reset();
      cur_gap = 0;
      add_csr(CSR_INITIAL_VALUE, 32'h0001_0000);
      add_req(REQ_STEP, 10'd5, 32'h0002_0000, 16'hFFFF, 4'hF, 4'h0);
      add_req(REQ_START, 10'd0, 32'h0, 16'hFFFF, 4'h0, 4'h0);
      add_req(REQ_START, 10'd0, 32'h0, 16'hFFFF, 4'h0, 4'hF);
      add_req(REQ_STEP, 10'd1023, 32'h7FFF_FFFF, 16'h0000, 4'hF, 4'h5);
      add_req(REQ_STEP, 10'd0, 32'h8000_0000, 16'h8000, 4'hA, 4'h3);
      add_req(REQ_NONE, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 4'hF);
      add_req(REQ_END, 10'd0, 32'h7FFF_FFFF, 16'h0, 4'h0, 4'h0);
      add_csr(CSR_NUM_ACTIONS, 32'd16);
      add_csr(CSR_LEARN_RATE, 32'd65536);
      add_csr(CSR_DISCOUNT, 32'd65536);
      add_csr(CSR_TRACE_DECAY, 32'd0);
      add_csr(CSR_EXPLORE_RATE, 32'd0);
      add_csr(CSR_INITIAL_VALUE, 32'h7FFF_0000);
      add_req(REQ_START, 10'd512, 32'h0, 16'h0, 4'h0, 4'hF);
      add_req(REQ_STEP, 10'd512, 32'h7FFF_FFFF, 16'hFFFF, 4'h0, 4'h7);
      add_req(REQ_STEP, 10'd513, 32'h8000_0000, 16'h1234, 4'h0, 4'h2);
      add_req(REQ_END, 10'd0, 32'h8000_0000, 16'h0, 4'h0, 4'h0);
      add_csr(CSR_NUM_ACTIONS, 32'd0);
      add_csr(CSR_LEARN_RATE, 32'h1FFFF);
      add_csr(CSR_DISCOUNT, 32'd0);
      add_csr(CSR_TRACE_DECAY, 32'h1FFFF);
      add_csr(CSR_EXPLORE_RATE, 32'h1FFFF);
      add_csr(CSR_INITIAL_VALUE, 32'h8000_0000);
      add_req(REQ_START, 10'd700, 32'h0, 16'hFFFF, 4'h9, 4'h0);
      add_req(REQ_STEP, 10'd700, 32'h0005_8000, 16'hFFFF, 4'h6, 4'h0);
      add_req(REQ_END, 10'd0, 32'hFFFF_8000, 16'h0, 4'h0, 4'h0);
      add_csr(CSR_NUM_ACTIONS, 32'd31);
      add_req(REQ_STEP, 10'd700, 32'h0001_0000, 16'h0, 4'h0, 4'hF);
      add_csr(CSR_NUM_ACTIONS, 32'd2);
      add_req(REQ_STEP, 10'd700, 32'h0001_0000, 16'hFFFF, 4'h0, 4'h1);
      add_req(REQ_END, 10'd0, 32'h0003_0000, 16'h0, 4'h0, 4'h0);

      add_csr(CSR_NUM_ACTIONS, 32'd4);
      add_csr(CSR_LEARN_RATE, 32'd16384);
      add_csr(CSR_DISCOUNT, 32'd58982);
      add_csr(CSR_TRACE_DECAY, 32'd52428);
      add_csr(CSR_EXPLORE_RATE, 32'd13107);
      add_csr(CSR_INITIAL_VALUE, 32'h0000_8000);
      cur_gap = 37;
      add_random(28);
      add_csr(CSR_NUM_ACTIONS, 32'd16);
      add_csr(CSR_EXPLORE_RATE, 32'd32768);
      add_csr(CSR_LEARN_RATE, 32'd65536);
      cur_gap = 47;
      add_random(28);
      add_csr(CSR_NUM_ACTIONS, 32'd7);
      add_csr(CSR_DISCOUNT, 32'd65536);
      add_csr(CSR_TRACE_DECAY, 32'd65536);
      add_csr(CSR_EXPLORE_RATE, 32'd3000);
      cur_gap = 0;
      add_random(28);
   end

   // Driver: one transaction or register write at a time from the job queue.
   always @(posedge clock) begin
      job_type j;
      bit      do_csr;
      do_csr = 1'b0;
      if (reset) begin
         start <= 1'b0;
         csr_write <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (start && !busy) begin
            choice_q.push_back(learner_apply(req_type, req_state_index, req_reward,
                                             req_explore_draw, req_random_action,
                                             req_tie_draw));
         end
         if (!(start && busy)) begin
            if (job_q.size() == 0) begin
               start <= 1'b0;
            end else if (job_q[0].is_csr) begin
               start <= 1'b0;
               // Registers change only once the core has been quiet for a while.
               if (quiet_cycles >= 40 && !start) begin
                  j = job_q.pop_front();
                  do_csr = 1'b1;
                  csr_index <= j.csr_idx;
                  csr_wdata <= j.csr_val;
                  learner_write_reg(j.csr_idx, j.csr_val);
               end
            end else if ($urandom_range(99) < job_q[0].gap_pct) begin
               start <= 1'b0;
            end else begin
               j = job_q.pop_front();
               start <= 1'b1;
               req_type <= j.kind;
               req_state_index <= j.state;
               req_reward <= j.reward;
               req_explore_draw <= j.draw;
               req_random_action <= j.rand_act;
               req_tie_draw <= j.tie;
            end
         end
         csr_write <= do_csr;
         if (do_csr) begin
            quiet_cycles <= 0;
         end else if (choice_q.size() == 0 && !busy && !start && !csr_write) begin
            quiet_cycles <= quiet_cycles + 1;
         end else begin
            quiet_cycles <= 0;
         end
      end
   end

   // Monitor: compare every strobed result with the oldest expected choice.
   always @(posedge clock) begin
      choice_type c;
      if (!reset && rsp_strobe) begin
         if (choice_q.size() == 0) begin
            $display("%0t: unexpected result action %0d valid %0d", $realtime,
                     rsp_chosen_action, rsp_action_valid);
            errors++;
         end else begin
            c = choice_q.pop_front();
            if (rsp_chosen_action !== c.action) begin
               $display("%0t: chosen_action expected %0d actual %0d", $realtime,
                        c.action, rsp_chosen_action);
               errors++;
            end
            if (rsp_action_valid !== c.valid) begin
               $display("%0t: action_valid expected %0d actual %0d", $realtime,
                        c.valid, rsp_action_valid);
               errors++;
            end
         end
      end
   end

   // Reset, then wait for the queues to drain and a settling period.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (job_q.size() == 0 && !start);
      wait (choice_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && choice_q.size() == 0) begin
         $display("sarsa_lambda_q_update_core verification clean");
      end else begin
         $display("sarsa_lambda_q_update_core verification failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #(64'd150_000_000);
      $display("sarsa_lambda_q_update_core verification failed");
      $finish;
   end

endmodule
